/* rtl/olad_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the ordered list with append and delete

package olad_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_DUMP   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_APPENDED = 3'd0,
      ST_FULL     = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_LISTED   = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_SEARCH,
      S_SHIFT,
      S_DUMP
   } state_type;

   localparam int unsigned VALUE_W = 32;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;      // capture request value, rewind read pointer
      logic       rd;        // read entry at pointer, advance pointer
      logic       seek;      // restart reads just past the matched entry
      logic       shift_wr;  // move the fetched entry one place toward the head
      logic       append_wr; // write request value at the tail
      logic       dec_cnt;   // drop one entry from the count
      logic       emit;      // present a result
      status_type emit_status;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic ptr_lt_cnt; // more entries left to read
      logic vld;        // fetched entry is in the read register
      logic match;      // fetched entry equals the request value
      logic dlast;      // fetched entry is the tail
      logic cnt_zero;   // list is empty
      logic full;       // list is full
   } sts_type;

endpackage

/* rtl/olad_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine for the ordered list

module olad_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_type,
   input  olad_pkg::sts_type     sts,
   output olad_pkg::cmd_type     cmd,
   output logic                  busy
);

   olad_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olad_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = olad_pkg::ST_APPENDED;
      unique case (state_ff)
         olad_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (olad_pkg::req_kind_type'(req_type))
                  olad_pkg::REQ_APPEND: state_in = olad_pkg::S_APPEND;
                  olad_pkg::REQ_REMOVE: state_in = olad_pkg::S_SEARCH;
                  olad_pkg::REQ_DUMP:   state_in = olad_pkg::S_DUMP;
                  default:              state_in = olad_pkg::S_IDLE;
               endcase
            end
         end
         olad_pkg::S_APPEND: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.full ? olad_pkg::ST_FULL : olad_pkg::ST_APPENDED;
            cmd.append_wr   = !sts.full;
            state_in        = olad_pkg::S_IDLE;
         end
         olad_pkg::S_SEARCH: begin
            if (sts.vld && sts.match) begin
               cmd.seek = 1'b1;
               state_in = olad_pkg::S_SHIFT;
            end else if (!sts.vld && !sts.ptr_lt_cnt) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = olad_pkg::ST_NOTFOUND;
               state_in        = olad_pkg::S_IDLE;
            end else begin
               cmd.rd = sts.ptr_lt_cnt;
            end
         end
         olad_pkg::S_SHIFT: begin
            cmd.rd       = sts.ptr_lt_cnt;
            cmd.shift_wr = sts.vld;
            if (!sts.vld && !sts.ptr_lt_cnt) begin
               cmd.dec_cnt     = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = olad_pkg::ST_REMOVED;
               state_in        = olad_pkg::S_IDLE;
            end
         end
         olad_pkg::S_DUMP: begin
            if (sts.cnt_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = olad_pkg::ST_EMPTY;
               state_in        = olad_pkg::S_IDLE;
            end else begin
               cmd.rd = sts.ptr_lt_cnt;
               if (sts.vld) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = olad_pkg::ST_LISTED;
                  if (sts.dlast) begin
                     state_in = olad_pkg::S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = olad_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != olad_pkg::S_IDLE);

endmodule

/* rtl/olad_dpath.sv */
`timescale 1ns / 1ps
// datapath for the ordered list: entry memory, count, read pointer, result register

module olad_dpath #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [olad_pkg::VALUE_W-1:0] req_item_value,
   input  olad_pkg::cmd_type                   cmd,
   output olad_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic signed [olad_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                rsp_last
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [olad_pkg::VALUE_W-1:0] mem [DEPTH];

   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 ptr_ff;
   logic                          vld_ff;
   logic [AW-1:0]                 dix_ff;
   logic [olad_pkg::VALUE_W-1:0]  rd_data_ff;
   logic [olad_pkg::VALUE_W-1:0]  val_ff;

   logic                          rsp_valid_ff;
   logic [2:0]                    rsp_status_ff;
   logic [olad_pkg::VALUE_W-1:0]  rsp_value_ff;
   logic                          rsp_last_ff;

   logic [CW-1:0]                 dix_next;
   logic [AW-1:0]                 dix_prev;
   logic                          listed;

   assign dix_next = CW'(dix_ff) + CW'(1);
   assign dix_prev = dix_ff - AW'(1);
   assign listed   = (cmd.emit_status == olad_pkg::ST_LISTED);

   assign sts.ptr_lt_cnt = (ptr_ff < count_ff);
   assign sts.vld        = vld_ff;
   assign sts.match      = (rd_data_ff == val_ff);
   assign sts.dlast      = (dix_next == count_ff);
   assign sts.cnt_zero   = (count_ff == '0);
   assign sts.full       = (count_ff == CW'(DEPTH));

   // memory port: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.append_wr) begin
         mem[count_ff[AW-1:0]] <= val_ff;
      end else if (cmd.shift_wr) begin
         mem[dix_prev] <= rd_data_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[ptr_ff[AW-1:0]];
         dix_ff     <= ptr_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         if (cmd.append_wr) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.dec_cnt) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.load) begin
            ptr_ff <= '0;
            vld_ff <= 1'b0;
         end else if (cmd.seek) begin
            ptr_ff <= dix_next;
            vld_ff <= 1'b0;
         end else begin
            if (cmd.rd) begin
               ptr_ff <= ptr_ff + CW'(1);
            end
            vld_ff <= cmd.rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_item_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_value_ff  <= listed ? rd_data_ff : '0;
         rsp_last_ff   <= !listed || sts.dlast;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* rtl/ordered_list_append_delete.sv */
`timescale 1ns / 1ps
// top level of the insertion-ordered list with append, remove and dump
//
// channel   ports                                      transfer when
// request   req_type, req_item_value                   start && !busy
// result    rsp_status, rsp_out_value, rsp_last        rsp_valid (one cycle)
//
// append: the result comes through S_APPEND and then the result register; busy only while in S_APPEND
// remove: the search and the gap-closing shift each walk the single read
//   port of the entry memory, one entry per cycle
// dump: one listed result per cycle after the registered memory read,
//   the last marked by rsp_last
// reset clears the count, so the list starts empty; memory is not cleared
// results cannot be held off: each shows for one cycle only

module ordered_list_append_delete #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic signed [olad_pkg::VALUE_W-1:0] req_item_value,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic signed [olad_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                rsp_last
);

   olad_pkg::cmd_type cmd;
   olad_pkg::sts_type sts;

   // sequencing of each request
   olad_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // entry store, pointers and the result register
   olad_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   // no result appears unless a request is under way
   a_no_idle_rsp : assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("result without a request in progress");

   // an append gets its result, marked last, through S_APPEND and the result register
   a_append_timing : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == olad_pkg::REQ_APPEND)
         |=> !rsp_valid ##1 (rsp_valid && rsp_last))
      else $error("append result out of time");

   // only listed entries carry a value, and everything else ends the request
   a_single_rsp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != olad_pkg::ST_LISTED)
         |-> (rsp_last && rsp_out_value == '0))
      else $error("status result not final or carries a value");

   // the shift write and the count decrement only happen while the block is busy
   a_shift_busy : assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_wr || cmd.dec_cnt) |-> busy)
      else $error("entry move outside a removal");

endmodule

/* sim/ordered_list_append_delete_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the insertion-ordered list with append, remove and dump

module ordered_list_append_delete_test;

   localparam int unsigned LIST_DEPTH = 32;
   localparam logic signed [olad_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [olad_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   // remove and dump walk the whole store, so the drain wait leaves room for that plus slack
   localparam int unsigned DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

   // one expected result of the list
   typedef struct {
      olad_pkg::status_type                 status;
      logic signed [olad_pkg::VALUE_W-1:0]  value;
      logic                                 last;
   } list_result_type;

   // shadow copy of the list plus the queue of results still owed by the block
   class list_scoreboard;
      logic signed [olad_pkg::VALUE_W-1:0] entries[$];
      list_result_type                     owed[$];
      int unsigned                         mismatches = 0;

      function int unsigned size();
         return entries.size();
      endfunction

      function logic signed [olad_pkg::VALUE_W-1:0] entry_at(int unsigned idx);
         return entries[idx];
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      function void owe(olad_pkg::status_type st,
                        logic signed [olad_pkg::VALUE_W-1:0] v, logic l);
         list_result_type r;
         r.status = st;
         r.value  = v;
         r.last   = l;
         owed.push_back(r);
      endfunction

      // update the shadow list for one accepted request and queue its results
      function void note_request(olad_pkg::req_kind_type kind,
                                 logic signed [olad_pkg::VALUE_W-1:0] v);
         int hit;
         hit = -1;
         case (kind)
            olad_pkg::REQ_APPEND: begin
               if (entries.size() >= LIST_DEPTH) begin
                  owe(olad_pkg::ST_FULL, '0, 1'b1);
               end else begin
                  entries.push_back(v);
                  owe(olad_pkg::ST_APPENDED, '0, 1'b1);
               end
            end
            olad_pkg::REQ_REMOVE: begin
               // only the match nearest the head goes
               for (int i = 0; i < entries.size(); i++) begin
                  if (hit < 0 && entries[i] == v) begin
                     hit = i;
                  end
               end
               if (hit < 0) begin
                  owe(olad_pkg::ST_NOTFOUND, '0, 1'b1);
               end else begin
                  entries.delete(hit);
                  owe(olad_pkg::ST_REMOVED, '0, 1'b1);
               end
            end
            olad_pkg::REQ_DUMP: begin
               if (entries.size() == 0) begin
                  owe(olad_pkg::ST_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < entries.size(); i++) begin
                     owe(olad_pkg::ST_LISTED, entries[i], (i == entries.size() - 1));
                  end
               end
            end
            default: begin
               // unused code: ignored, nothing owed
            end
         endcase
      endfunction

      function void check_result(logic [2:0] st, logic signed [olad_pkg::VALUE_W-1:0] v,
                                 logic l);
         list_result_type e;
         if (owed.size() == 0) begin
            $display("%0t: result with nothing owed: status %0d value %0d last %0b",
                     $time, st, v, l);
            mismatches++;
            return;
         end
         e = owed.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d (%s), actual %0d",
                     $time, e.status, e.status.name(), st);
            mismatches++;
         end
         if (v !== e.value) begin
            $display("%0t: out_value expected %0d, actual %0d", $time, e.value, v);
            mismatches++;
         end
         if (l !== e.last) begin
            $display("%0t: last expected %0b, actual %0b", $time, e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [1:0]                           req_type;
   logic signed [olad_pkg::VALUE_W-1:0]  req_item_value;
   logic                                 rsp_valid;
   logic [2:0]                           rsp_status;
   logic signed [olad_pkg::VALUE_W-1:0]  rsp_out_value;
   logic                                 rsp_last;

   list_scoreboard sb;

   // small pool of recurring values so duplicates and hits on remove are common
   logic signed [olad_pkg::VALUE_W-1:0] value_pool[8];

   ordered_list_append_delete #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // present one request and hold it until the block takes it; start is left
   // high so a following request can go back to back
   task automatic send_request(olad_pkg::req_kind_type kind,
                               logic signed [olad_pkg::VALUE_W-1:0] v);
      start          <= 1'b1;
      req_type       <= kind;
      req_item_value <= v;
      // busy read straight after the edge is still its pre-edge value
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(kind, v);
   endtask

   // drop start for a burst of idle cycles
   task automatic idle_burst(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // mix of fully random values, pool values and the extremes
   function automatic logic signed [olad_pkg::VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return $urandom;
      if (roll < 9) return value_pool[$urandom_range(0, 7)];
      return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
   endfunction

   // remove values mostly hit something already stored
   function automatic logic signed [olad_pkg::VALUE_W-1:0] pick_victim();
      if (sb.size() != 0 && $urandom_range(0, 9) < 7) begin
         return sb.entry_at($urandom_range(0, sb.size() - 1));
      end
      return pick_value();
   endfunction

   // results cannot be held off, so every strobed cycle is one transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         sb.check_result(rsp_status, rsp_out_value, rsp_last);
      end
   end

   initial begin
      int unsigned            sent;
      int unsigned            phase;
      int unsigned            full_hits;
      int unsigned            miss_hits;
      int unsigned            mixed_sent;
      int unsigned            roll;
      olad_pkg::req_kind_type kind;

      sb             = new;
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = olad_pkg::REQ_APPEND;
      req_item_value = '0;
      value_pool[0]  = '0;
      value_pool[1]  = -1;
      value_pool[2]  = 1;
      for (int i = 3; i < 8; i++) value_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, extremes, duplicates, head, tail and misses
      send_request(olad_pkg::REQ_DUMP, '0);                  // empty status
      send_request(olad_pkg::REQ_REMOVE, 32'sd7);            // miss on an empty list
      send_request(olad_pkg::REQ_APPEND, '0);                // zero is an ordinary value
      send_request(olad_pkg::REQ_APPEND, VAL_MIN);
      send_request(olad_pkg::REQ_APPEND, VAL_MAX);
      send_request(olad_pkg::REQ_APPEND, -1);
      send_request(olad_pkg::REQ_APPEND, 32'sd1);
      send_request(olad_pkg::REQ_APPEND, VAL_MAX);           // duplicate
      send_request(olad_pkg::REQ_APPEND, 32'sh5555_5555);
      send_request(olad_pkg::REQ_APPEND, 32'shAAAA_AAAA);
      send_request(olad_pkg::REQ_DUMP, 32'shFFFF_FFFF);      // value ignored on dump
      send_request(olad_pkg::REQ_REMOVE, VAL_MAX);           // only the first duplicate goes
      send_request(olad_pkg::REQ_REMOVE, 32'sd12345);        // miss
      send_request(olad_pkg::REQ_REMOVE, 32'shAAAA_AAAA);    // tail
      send_request(olad_pkg::REQ_REMOVE, '0);                // head
      send_request(olad_pkg::REQ_UNUSED, 32'sh1234_5678);    // ignored, nothing comes back
      send_request(olad_pkg::REQ_DUMP, '0);
      send_request(olad_pkg::REQ_REMOVE, VAL_MAX);           // the second copy this time
      send_request(olad_pkg::REQ_APPEND, '0);
      send_request(olad_pkg::REQ_DUMP, '0);

      // random: fill until full several times over, drain until empty and
      // missing, then a mixed run with no idling at the end
      sent       = 0;
      phase      = 0;
      full_hits  = 0;
      miss_hits  = 0;
      mixed_sent = 0;
      while (phase < 2 || sent < 120 || mixed_sent < 25) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // noise: unused code, not counted
            send_request(olad_pkg::REQ_UNUSED, $urandom);
         end else begin
            roll = $urandom_range(0, 99);
            case (phase)
               0: begin
                  kind = (roll < 80) ? olad_pkg::REQ_APPEND :
                         (roll < 88) ? olad_pkg::REQ_REMOVE : olad_pkg::REQ_DUMP;
               end
               1: begin
                  kind = (roll < 12) ? olad_pkg::REQ_APPEND :
                         (roll < 85) ? olad_pkg::REQ_REMOVE : olad_pkg::REQ_DUMP;
               end
               default: begin
                  kind = (roll < 45) ? olad_pkg::REQ_APPEND :
                         (roll < 85) ? olad_pkg::REQ_REMOVE : olad_pkg::REQ_DUMP;
               end
            endcase
            if (kind == olad_pkg::REQ_APPEND && sb.size() == LIST_DEPTH) full_hits++;
            if (kind == olad_pkg::REQ_REMOVE && sb.size() == 0) miss_hits++;
            if (kind == olad_pkg::REQ_REMOVE) begin
               send_request(kind, pick_victim());
            end else begin
               send_request(kind, (kind == olad_pkg::REQ_DUMP) ? $urandom : pick_value());
            end
            sent++;
            if (phase == 2) mixed_sent++;
         end
         if (phase == 0 && full_hits >= 3) phase = 1;
         if (phase == 1 && miss_hits >= 2) phase = 2;
         // idling only before the closing stretch
         if (mixed_sent < 10 && $urandom_range(0, 3) == 0) begin
            idle_burst($urandom_range(1, 19));
         end
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(5_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
